@@ src/rsi_pkg.sv @@
package rsi_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int DIR_FRAC_BITS   = 30;

  localparam logic [30:0] RADIUS_RESET = 31'(1) << COORD_FRAC_BITS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // one result bit per stage
  localparam int SQ_STAGES  = 67;
  localparam int DIV_STAGES = 61;
  localparam int NRM_STAGES = 31;

  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_RADIUS
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] orig_x;
    logic signed [31:0] orig_y;
    logic signed [31:0] orig_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
  } ray_in_t;

  typedef struct packed {
    logic               hit_found;
    logic signed [31:0] hit_dist;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } hit_out_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] sphere_radius;
  } sphere_cfg_t;

  // classified ray handed from front to back
  typedef struct packed {
    logic               miss;
    logic [133:0]       disc;
    logic signed [66:0] h;
    ray_in_t            ray;
  } fe_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [31:0] r;
    if (x > 72'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -72'sh80000000) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/rsi_mul.sv @@
module rsi_mul (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [67:0]  a_i,
  input  logic signed [67:0]  b_i,
  output logic signed [135:0] p_o
);

  logic [67:0]  ma_q, mb_q;
  logic         neg1_q, neg2_q;
  logic [67:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [135:0] sum;
  logic signed [135:0] p_q;

  // magnitudes, then four 34x34 partial products, then sum and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= a_i[67] ? 68'(-a_i) : 68'(a_i);
      mb_q   <= b_i[67] ? 68'(-b_i) : 68'(b_i);
      neg1_q <= a_i[67] ^ b_i[67];
      pp00_q <= ma_q[33:0]  * mb_q[33:0];
      pp01_q <= ma_q[33:0]  * mb_q[67:34];
      pp10_q <= ma_q[67:34] * mb_q[33:0];
      pp11_q <= ma_q[67:34] * mb_q[67:34];
      neg2_q <= neg1_q;
      p_q    <= neg2_q ? -signed'(sum) : signed'(sum);
    end
  end

  always_comb begin
    sum = 136'(pp00_q) + ((136'(pp01_q) + 136'(pp10_q)) << 34) + (136'(pp11_q) << 68);
  end

  assign p_o = p_q;

endmodule

@@ src/rsi_front.sv @@
module rsi_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rsi_pkg::ray_in_t     in_data_i,
  input  rsi_pkg::sphere_cfg_t cfg_i,
  output logic                 fe_valid_o,
  output rsi_pkg::fe_item_t    fe_data_o,
  input  logic                 fe_stall_i
);
  import rsi_pkg::*;

  logic [8:0] vld_q;
  logic       adv;

  ray_in_t            ray0_q;
  logic signed [32:0] co_q [3];
  ray_in_t            ray_a_q [3];
  logic signed [135:0] phx, phy, phz, pcx, pcy, pcz, prr;
  logic signed [66:0] h4_q;
  logic signed [67:0] cc4_q;
  ray_in_t            ray4_q;
  logic signed [135:0] phh;
  logic signed [66:0] h_b_q [3];
  logic signed [67:0] cc_b_q [3];
  ray_in_t            ray_b_q [3];
  logic signed [135:0] disc_d;
  fe_item_t           fe_q;

  assign adv        = !vld_q[8] || !fe_stall_i;
  assign in_stall_o = !adv;
  assign fe_valid_o = vld_q[8];
  assign fe_data_o  = fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[7:0], in_valid_i};
    end
  end

  // offset of the origin from the center
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray0_q   <= in_data_i;
      co_q[0]  <= 33'(in_data_i.orig_x) - 33'(cfg_i.center_x);
      co_q[1]  <= 33'(in_data_i.orig_y) - 33'(cfg_i.center_y);
      co_q[2]  <= 33'(in_data_i.orig_z) - 33'(cfg_i.center_z);
    end
  end

  rsi_mul u_mul_hx (.clk_i, .en_i(adv), .a_i(68'(co_q[0])), .b_i(68'(ray0_q.dir_x)), .p_o(phx));
  rsi_mul u_mul_hy (.clk_i, .en_i(adv), .a_i(68'(co_q[1])), .b_i(68'(ray0_q.dir_y)), .p_o(phy));
  rsi_mul u_mul_hz (.clk_i, .en_i(adv), .a_i(68'(co_q[2])), .b_i(68'(ray0_q.dir_z)), .p_o(phz));
  rsi_mul u_mul_cx (.clk_i, .en_i(adv), .a_i(68'(co_q[0])), .b_i(68'(co_q[0])), .p_o(pcx));
  rsi_mul u_mul_cy (.clk_i, .en_i(adv), .a_i(68'(co_q[1])), .b_i(68'(co_q[1])), .p_o(pcy));
  rsi_mul u_mul_cz (.clk_i, .en_i(adv), .a_i(68'(co_q[2])), .b_i(68'(co_q[2])), .p_o(pcz));
  rsi_mul u_mul_rr (.clk_i, .en_i(adv), .a_i(68'(cfg_i.sphere_radius)),
                    .b_i(68'(cfg_i.sphere_radius)), .p_o(prr));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray_a_q[0] <= ray0_q;
      ray_a_q[1] <= ray_a_q[0];
      ray_a_q[2] <= ray_a_q[1];
      h4_q       <= 67'(phx) + 67'(phy) + 67'(phz);
      cc4_q      <= 68'(pcx) + 68'(pcy) + 68'(pcz) - 68'(prr);
      ray4_q     <= ray_a_q[2];
    end
  end

  rsi_mul u_mul_hh (.clk_i, .en_i(adv), .a_i(68'(h4_q)), .b_i(68'(h4_q)), .p_o(phh));

  always_comb begin
    disc_d = phh - (136'(cc_b_q[2]) <<< (2 * DIR_FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_b_q[0]   <= h4_q;
      h_b_q[1]   <= h_b_q[0];
      h_b_q[2]   <= h_b_q[1];
      cc_b_q[0]  <= cc4_q;
      cc_b_q[1]  <= cc_b_q[0];
      cc_b_q[2]  <= cc_b_q[1];
      ray_b_q[0] <= ray4_q;
      ray_b_q[1] <= ray_b_q[0];
      ray_b_q[2] <= ray_b_q[1];
      fe_q.miss  <= disc_d[135];
      fe_q.disc  <= disc_d[133:0];
      fe_q.h     <= h_b_q[2];
      fe_q.ray   <= ray_b_q[2];
    end
  end

endmodule

@@ src/rsi_fifo.sv @@
module rsi_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_stall_o,
  input  rsi_pkg::fe_item_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_i,
  output rsi_pkg::fe_item_t pop_data_o
);
  import rsi_pkg::*;

  fe_item_t           mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               push;

  assign push_stall_o = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH)) else $error("queue count overflow");
`endif

endmodule

@@ src/rsi_back.sv @@
module rsi_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fe_valid_i,
  output logic                 fe_pop_o,
  input  rsi_pkg::fe_item_t    fe_data_i,
  input  rsi_pkg::sphere_cfg_t cfg_i,
  output logic                 out_valid_o,
  output rsi_pkg::hit_out_t    out_data_o,
  input  logic                 out_stall_i
);
  import rsi_pkg::*;

  localparam int NB = SQ_STAGES + 1 + 3 + 1 + 3 + 1 + DIV_STAGES + NRM_STAGES + 1;

  typedef struct packed {
    logic [69:0]        rem;
    logic [66:0]        root;
    logic [133:0]       rad;
    logic               miss;
    logic signed [66:0] h;
    ray_in_t            ray;
  } sq_t;

  typedef struct packed {
    logic               hit;
    logic signed [38:0] tq;
    ray_in_t            ray;
  } rs_t;

  typedef struct packed {
    logic              hit;
    logic [31:0]       hdist;
    logic [2:0][31:0]  pnt;
    logic [2:0]        vneg;
  } pt_t;

  typedef struct packed {
    pt_t              base;
    logic [2:0][83:0] vv;
    logic [85:0]      l2;
  } ll_t;

  typedef struct packed {
    pt_t              base;
    logic             deg;
    logic [85:0]      l2;
    logic [2:0][85:0] rem;
    logic [2:0][60:0] q;
  } dv_t;

  typedef struct packed {
    pt_t              base;
    logic             deg;
    logic [2:0][33:0] rem;
    logic [2:0][30:0] root;
    logic [2:0][61:0] rad;
  } s2_t;

  logic [NB-1:0] bvld_q;
  logic          adv;

  sq_t sq_q [SQ_STAGES];
  sq_t sq_in [SQ_STAGES];
  sq_t sq_d [SQ_STAGES];

  logic signed [68:0] neg_h, s_ext, root_n, root_f, root_sel;
  logic signed [38:0] tq_d;
  rs_t                rs_q;
  rs_t                rs_c_q [3];
  logic signed [135:0] pc [3];

  logic signed [31:0] o_sel [3];
  logic signed [31:0] c_sel [3];
  logic signed [71:0] psum [3];
  logic signed [41:0] p_d [3];
  logic signed [42:0] v_d [3];
  logic signed [42:0] v_q [3];
  pt_t                pt_d, pt_q;
  pt_t                pt_dl_q [3];
  logic signed [135:0] pv [3];
  ll_t                ll_q;

  dv_t dv_q [DIV_STAGES];
  dv_t dv_in [DIV_STAGES];
  dv_t dv_d [DIV_STAGES];

  s2_t s2_q [NRM_STAGES];
  s2_t s2_in [NRM_STAGES];
  s2_t s2_d [NRM_STAGES];

  hit_out_t out_d, out_q;

  assign adv         = !bvld_q[NB-1] || !out_stall_i;
  assign fe_pop_o    = adv && fe_valid_i;
  assign out_valid_o = bvld_q[NB-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q <= '0;
    end else if (adv) begin
      bvld_q <= {bvld_q[NB-2:0], fe_valid_i};
    end
  end

  // square root of the discriminant, two radicand bits per stage
  always_comb begin
    logic [69:0] acc;
    logic [69:0] trial;
    sq_in[0]      = '0;
    sq_in[0].rad  = fe_data_i.disc;
    sq_in[0].miss = fe_data_i.miss;
    sq_in[0].h    = fe_data_i.h;
    sq_in[0].ray  = fe_data_i.ray;
    for (int k = 1; k < SQ_STAGES; k++) sq_in[k] = sq_q[k-1];
    for (int k = 0; k < SQ_STAGES; k++) begin
      acc       = {sq_in[k].rem[67:0], sq_in[k].rad[133:132]};
      trial     = {1'b0, sq_in[k].root, 2'b01};
      sq_d[k]   = sq_in[k];
      sq_d[k].rad = {sq_in[k].rad[131:0], 2'b00};
      if (acc >= trial) begin
        sq_d[k].rem  = acc - trial;
        sq_d[k].root = {sq_in[k].root[65:0], 1'b1};
      end else begin
        sq_d[k].rem  = acc;
        sq_d[k].root = {sq_in[k].root[65:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < SQ_STAGES; k++) sq_q[k] <= sq_d[k];
    end
  end

  // take the near root, or the far one when the near one is behind the origin
  always_comb begin
    neg_h    = -69'(sq_q[SQ_STAGES-1].h);
    s_ext    = signed'({2'b00, sq_q[SQ_STAGES-1].root});
    root_n   = neg_h - s_ext;
    root_f   = neg_h + s_ext;
    root_sel = root_n[68] ? root_f : root_n;
    tq_d     = root_sel[68:DIR_FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs_q.tq  <= tq_d;
      rs_q.ray <= sq_q[SQ_STAGES-1].ray;
      rs_q.hit <= !sq_q[SQ_STAGES-1].miss
                  && (tq_d > 39'(sq_q[SQ_STAGES-1].ray.t_near))
                  && (tq_d < 39'(sq_q[SQ_STAGES-1].ray.t_far));
      rs_c_q[0] <= rs_q;
      rs_c_q[1] <= rs_c_q[0];
      rs_c_q[2] <= rs_c_q[1];
    end
  end

  rsi_mul u_mul_px (.clk_i, .en_i(adv), .a_i(68'(rs_q.tq)), .b_i(68'(rs_q.ray.dir_x)), .p_o(pc[0]));
  rsi_mul u_mul_py (.clk_i, .en_i(adv), .a_i(68'(rs_q.tq)), .b_i(68'(rs_q.ray.dir_y)), .p_o(pc[1]));
  rsi_mul u_mul_pz (.clk_i, .en_i(adv), .a_i(68'(rs_q.tq)), .b_i(68'(rs_q.ray.dir_z)), .p_o(pc[2]));

  // hit point and its offset from the center
  always_comb begin
    o_sel[0] = rs_c_q[2].ray.orig_x;
    o_sel[1] = rs_c_q[2].ray.orig_y;
    o_sel[2] = rs_c_q[2].ray.orig_z;
    c_sel[0] = cfg_i.center_x;
    c_sel[1] = cfg_i.center_y;
    c_sel[2] = cfg_i.center_z;
    pt_d.hit   = rs_c_q[2].hit;
    pt_d.hdist = sat32(72'(rs_c_q[2].tq));
    for (int a = 0; a < 3; a++) begin
      psum[a]     = (72'(o_sel[a]) <<< DIR_FRAC_BITS) + 72'(pc[a]);
      p_d[a]      = psum[a][71:DIR_FRAC_BITS];
      v_d[a]      = 43'(p_d[a]) - 43'(c_sel[a]);
      pt_d.pnt[a] = sat32(72'(p_d[a]));
      pt_d.vneg[a] = v_d[a][42];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q <= pt_d;
      for (int a = 0; a < 3; a++) v_q[a] <= v_d[a];
      pt_dl_q[0] <= pt_q;
      pt_dl_q[1] <= pt_dl_q[0];
      pt_dl_q[2] <= pt_dl_q[1];
    end
  end

  rsi_mul u_mul_vx (.clk_i, .en_i(adv), .a_i(68'(v_q[0])), .b_i(68'(v_q[0])), .p_o(pv[0]));
  rsi_mul u_mul_vy (.clk_i, .en_i(adv), .a_i(68'(v_q[1])), .b_i(68'(v_q[1])), .p_o(pv[1]));
  rsi_mul u_mul_vz (.clk_i, .en_i(adv), .a_i(68'(v_q[2])), .b_i(68'(v_q[2])), .p_o(pv[2]));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ll_q.base <= pt_dl_q[2];
      for (int a = 0; a < 3; a++) ll_q.vv[a] <= pv[a][83:0];
      ll_q.l2 <= 86'(pv[0][83:0]) + 86'(pv[1][83:0]) + 86'(pv[2][83:0]);
    end
  end

  // restoring division of v^2 * 2^60 by |v|^2, one quotient bit per stage
  always_comb begin
    logic [86:0] acc;
    dv_in[0]      = '0;
    dv_in[0].base = ll_q.base;
    dv_in[0].l2   = ll_q.l2;
    dv_in[0].deg  = (ll_q.l2 == '0);
    for (int k = 1; k < DIV_STAGES; k++) dv_in[k] = dv_q[k-1];
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv_d[k] = dv_in[k];
      for (int a = 0; a < 3; a++) begin
        acc = (k == 0) ? 87'(ll_q.vv[a]) : {dv_in[k].rem[a], 1'b0};
        if (acc >= 87'(dv_in[k].l2)) begin
          dv_d[k].rem[a] = 86'(acc - 87'(dv_in[k].l2));
          dv_d[k].q[a]   = {dv_in[k].q[a][59:0], 1'b1};
        end else begin
          dv_d[k].rem[a] = 86'(acc);
          dv_d[k].q[a]   = {dv_in[k].q[a][59:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) dv_q[k] <= dv_d[k];
    end
  end

  // square root of each quotient gives the normal magnitude
  always_comb begin
    logic [33:0] acc;
    logic [33:0] trial;
    s2_in[0]      = '0;
    s2_in[0].base = dv_q[DIV_STAGES-1].base;
    s2_in[0].deg  = dv_q[DIV_STAGES-1].deg;
    for (int a = 0; a < 3; a++) s2_in[0].rad[a] = {1'b0, dv_q[DIV_STAGES-1].q[a]};
    for (int k = 1; k < NRM_STAGES; k++) s2_in[k] = s2_q[k-1];
    for (int k = 0; k < NRM_STAGES; k++) begin
      s2_d[k] = s2_in[k];
      for (int a = 0; a < 3; a++) begin
        acc   = {s2_in[k].rem[a][31:0], s2_in[k].rad[a][61:60]};
        trial = {1'b0, s2_in[k].root[a], 2'b01};
        s2_d[k].rad[a] = {s2_in[k].rad[a][59:0], 2'b00};
        if (acc >= trial) begin
          s2_d[k].rem[a]  = acc - trial;
          s2_d[k].root[a] = {s2_in[k].root[a][29:0], 1'b1};
        end else begin
          s2_d[k].rem[a]  = acc;
          s2_d[k].root[a] = {s2_in[k].root[a][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NRM_STAGES; k++) s2_q[k] <= s2_d[k];
    end
  end

  // zero every field on a miss, and the normal when the point is the center
  always_comb begin
    logic [2:0][31:0] nrm;
    for (int a = 0; a < 3; a++) begin
      nrm[a] = s2_q[NRM_STAGES-1].base.vneg[a] ? -32'(s2_q[NRM_STAGES-1].root[a])
                                               : 32'(s2_q[NRM_STAGES-1].root[a]);
      if (s2_q[NRM_STAGES-1].deg) nrm[a] = '0;
    end
    out_d = '0;
    if (s2_q[NRM_STAGES-1].base.hit) begin
      out_d.hit_found = 1'b1;
      out_d.hit_dist  = s2_q[NRM_STAGES-1].base.hdist;
      out_d.point_x   = s2_q[NRM_STAGES-1].base.pnt[0];
      out_d.point_y   = s2_q[NRM_STAGES-1].base.pnt[1];
      out_d.point_z   = s2_q[NRM_STAGES-1].base.pnt[2];
      out_d.normal_x  = nrm[0];
      out_d.normal_y  = nrm[1];
      out_d.normal_z  = nrm[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit_found |->
      out_data_o.hit_dist == '0 && out_data_o.point_x == '0 && out_data_o.normal_x == '0)
    else $error("miss result carries nonzero fields");
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(bvld_q)) else $error("pipeline moved while stalled");
  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit_found |->
      out_data_o.normal_x <= 32'sh40000000 && out_data_o.normal_x >= -32'sh40000000)
    else $error("normal out of unit range");
`endif

endmodule

@@ src/ray_sphere_intersect_unit.sv @@
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------
// in       | input     | in_valid_i/in_stall_o   | ray_in_t  (origin, dir, window)
// out      | output    | out_valid_o/out_stall_i | hit_out_t (hit, dist, point, normal)
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One ray per cycle sustained while out_stall_i stays low. The front, the queue and the
// back are registered; the bit-per-stage square root and divider set the back's depth.
// Reset: center 0, radius 1.0, all pipelines and the queue empty.
// Output stall freezes the back; the 4-entry queue absorbs the front until full,
// then in_stall_o rises. cfg_ready_o is always high.
module ray_sphere_intersect_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rsi_pkg::ray_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsi_pkg::hit_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import rsi_pkg::*;

  sphere_cfg_t cfg_d, cfg_q;
  logic        fe_valid, fe_full, q_valid, q_pop;
  fe_item_t    fe_item, q_item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X: cfg_d.center_x      = cfg_data_i;
        REG_CENTER_Y: cfg_d.center_y      = cfg_data_i;
        REG_CENTER_Z: cfg_d.center_z      = cfg_data_i;
        REG_RADIUS:   cfg_d.sphere_radius = cfg_data_i[30:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x      <= '0;
      cfg_q.center_y      <= '0;
      cfg_q.center_z      <= '0;
      cfg_q.sphere_radius <= RADIUS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rsi_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .cfg_i      (cfg_q),
    .fe_valid_o (fe_valid),
    .fe_data_o  (fe_item),
    .fe_stall_i (fe_full)
  );

  rsi_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_valid_i (fe_valid),
    .push_stall_o (fe_full),
    .push_data_i  (fe_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_item)
  );

  rsi_back u_back (
    .clk_i,
    .rst_ni,
    .fe_valid_i  (q_valid),
    .fe_pop_o    (q_pop),
    .fe_data_i   (q_item),
    .cfg_i       (cfg_q),
    .out_valid_o,
    .out_data_o,
    .out_stall_i
  );

endmodule
